/* hw/rtl/clv_pkg.sv */
// ----------------------------------------------------------------------------
// clv_pkg
// Shared types, codes and constants of the checksummed line verifier.
// ----------------------------------------------------------------------------
package clv_pkg;

    // Default chunk bound: a chunk holds at most LINE_CAP_DEF - 1 bytes, newline excluded.
    localparam int LINE_CAP_DEF = 1024;

    // FNV-1a 32-bit constants.
    localparam logic [31:0] FNV_OFFSET = 32'd2166136261;
    localparam logic [31:0] FNV_PRIME  = 32'd16777619;

    // Characters that steer the framing and the field parser.
    localparam logic [7:0] CH_NL    = 8'h0A;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_HASH  = 8'h23;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_VT    = 8'h0B;
    localparam logic [7:0] CH_FF    = 8'h0C;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_LOW_X = 8'h78;
    localparam logic [7:0] CH_UP_X  = 8'h58;

    // Digit value reported for a byte that is not a hex digit.
    localparam logic [4:0] NOT_HEX = 5'd16;

    // Phase of the checksum field parser.
    typedef enum logic [2:0] {
        PH_LEAD   = 3'd0,
        PH_SIGN   = 3'd1,
        PH_ZERO   = 3'd2,
        PH_PREFIX = 3'd3,
        PH_DIGITS = 3'd4,
        PH_FAIL   = 3'd7
    } t_phase;

    // Verdict of a closed chunk.
    typedef enum logic [1:0] {
        V_VALID   = 2'd0,
        V_INVALID = 2'd1,
        V_SKIP    = 2'd2
    } t_verdict;

    // Value of a hex digit character, or NOT_HEX.
    function automatic logic [4:0] hex_value(input logic [7:0] c);
        logic [4:0] d;
        d = NOT_HEX;
        if (c >= 8'h30 && c <= 8'h39) begin
            d = 5'(c - 8'h30);
        end else if (c >= 8'h61 && c <= 8'h66) begin
            d = 5'(c - 8'h57);
        end else if (c >= 8'h41 && c <= 8'h46) begin
            d = 5'(c - 8'h37);
        end
        return d;
    endfunction

endpackage

/* hw/rtl/checksummed_line_verifier.sv */
// ----------------------------------------------------------------------------
// checksummed_line_verifier
// Splits a byte stream into lines, hashes the text before the last tab with
// FNV-1a-32 and checks it against the hex checksum field after that tab.
// ----------------------------------------------------------------------------
// A beat is held in the input register; the working stage then loads a closed
// chunk's verdict into the result register. Throughput: one byte per cycle while
// no closing byte waits for room in the result register; the hash update (xor
// and constant multiply) and the field parser are combinational.
// Reset (synchronous, active low) clears the counters, the chunk state and
// the valid flags of both pipeline registers.
module checksummed_line_verifier #(
    parameter int LINE_CAP = clv_pkg::LINE_CAP_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    // Input channel.
    input  logic                      i_in_valid,
    output logic                      o_in_ready,
    input  logic [7:0]                i_data_byte,
    input  logic                      i_end_of_stream,
    // Result channel.
    output logic                      o_out_valid,
    input  logic                      i_out_ready,
    output clv_pkg::t_verdict         o_verdict,
    output logic [31:0]               o_valid_count,
    output logic [31:0]               o_invalid_count,
    output logic [31:0]               o_computed_hash,
    output logic [31:0]               o_stored_value
);
    import clv_pkg::*;

    localparam int LEN_W = (LINE_CAP > 2) ? $clog2(LINE_CAP) : 1;
    localparam logic [LEN_W-1:0] LEN_LAST = LEN_W'(LINE_CAP - 1);

    // Input register.
    logic             r_in_valid;
    logic [7:0]       r_in_byte;
    logic             r_in_eos;

    // Chunk state.
    logic [31:0]      r_hash, n_hash;
    logic [31:0]      r_hash_tab, n_hash_tab;
    logic             r_tab_seen, n_tab_seen;
    t_phase           r_phase, n_phase;
    logic             r_neg, n_neg;
    logic [63:0]      r_parsed, n_parsed;
    logic             r_ovf, n_ovf;
    logic [LEN_W-1:0] r_len, n_len;
    logic             r_comment, n_comment;
    logic [31:0]      r_good, n_good;
    logic [31:0]      r_bad, n_bad;

    // Result register.
    logic             r_out_valid;
    t_verdict         r_verdict, n_verdict;
    logic [31:0]      r_out_hash, n_out_hash;
    logic [31:0]      r_out_stored, n_out_stored;

    // Per-byte helpers.
    logic             w_emit;
    logic             w_advance;
    logic             w_out_free;
    logic [4:0]       w_digit;
    logic             w_is_digit;
    logic [31:0]      w_mix;
    logic [31:0]      w_hash_step;
    logic [31:0]      w_stored;
    t_phase           w_phase_step;
    logic             w_neg_step;
    logic             w_add;
    logic [63:0]      w_parsed_step;
    logic             w_ovf_step;
    logic [LEN_W-1:0] w_len_inc;

    // Handshake: the working stage moves when its result, if any, has room.
    assign w_out_free = !r_out_valid || i_out_ready;
    assign w_advance  = r_in_valid && (!w_emit || w_out_free);
    assign o_in_ready = !r_in_valid || w_advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in_byte <= i_data_byte;
            r_in_eos  <= i_end_of_stream;
        end
    end

    // FNV-1a step on the current byte.
    assign w_mix       = r_hash ^ {24'd0, r_in_byte};
    assign w_hash_step = w_mix * FNV_PRIME;
    assign w_len_inc   = r_len + LEN_W'(1);

    // Field parser: next phase, sign and digit accumulation for one byte.
    assign w_digit    = hex_value(r_in_byte);
    assign w_is_digit = !w_digit[4];

    always_comb begin
        w_phase_step = r_phase;
        w_neg_step   = r_neg;
        w_add        = 1'b0;
        case (r_phase)
            PH_LEAD: begin
                if (r_in_byte inside {CH_SPACE, CH_VT, CH_FF, CH_CR}) begin
                    w_phase_step = PH_LEAD;
                end else if (r_in_byte inside {CH_PLUS, CH_MINUS}) begin
                    w_neg_step   = (r_in_byte == CH_MINUS);
                    w_phase_step = PH_SIGN;
                end else if (r_in_byte == CH_ZERO) begin
                    w_phase_step = PH_ZERO;
                end else if (w_is_digit) begin
                    w_add        = 1'b1;
                    w_phase_step = PH_DIGITS;
                end else begin
                    w_phase_step = PH_FAIL;
                end
            end
            PH_SIGN: begin
                if (r_in_byte == CH_ZERO) begin
                    w_phase_step = PH_ZERO;
                end else if (w_is_digit) begin
                    w_add        = 1'b1;
                    w_phase_step = PH_DIGITS;
                end else begin
                    w_phase_step = PH_FAIL;
                end
            end
            PH_ZERO: begin
                if (r_in_byte inside {CH_LOW_X, CH_UP_X}) begin
                    w_phase_step = PH_PREFIX;
                end else if (w_is_digit) begin
                    w_add        = 1'b1;
                    w_phase_step = PH_DIGITS;
                end else begin
                    w_phase_step = PH_FAIL;
                end
            end
            PH_PREFIX, PH_DIGITS: begin
                if (w_is_digit) begin
                    w_add        = 1'b1;
                    w_phase_step = PH_DIGITS;
                end else begin
                    w_phase_step = PH_FAIL;
                end
            end
            default: begin
                w_phase_step = PH_FAIL;
            end
        endcase
    end

    // Digit accumulation; a value that would pass 64 bits saturates.
    always_comb begin
        w_parsed_step = r_parsed;
        w_ovf_step    = r_ovf;
        if (w_add && !r_ovf) begin
            if (r_parsed[63:60] != 4'd0) begin
                w_ovf_step = 1'b1;
            end else begin
                w_parsed_step = {r_parsed[59:0], w_digit[3:0]};
            end
        end
    end

    // Checksum field value as stored: saturated, negated or plain.
    always_comb begin
        if (r_ovf) begin
            w_stored = '1;
        end else if (r_neg) begin
            w_stored = 32'd0 - r_parsed[31:0];
        end else begin
            w_stored = r_parsed[31:0];
        end
    end

    // Chunk framing, verdict and next chunk state.
    always_comb begin
        n_hash       = r_hash;
        n_hash_tab   = r_hash_tab;
        n_tab_seen   = r_tab_seen;
        n_phase      = r_phase;
        n_neg        = r_neg;
        n_parsed     = r_parsed;
        n_ovf        = r_ovf;
        n_len        = r_len;
        n_comment    = r_comment;
        n_good       = r_good;
        n_bad        = r_bad;
        w_emit       = 1'b0;
        n_verdict    = V_INVALID;
        n_out_hash   = 32'd0;
        n_out_stored = 32'd0;

        if (r_in_eos) begin
            w_emit = (r_len != '0);
        end else if (r_in_byte == CH_NL) begin
            w_emit = 1'b1;
            if (r_len == '0 || r_comment) begin
                n_verdict = V_SKIP;
            end else if (!r_tab_seen) begin
                n_verdict = V_INVALID;
            end else if (!(r_phase inside {PH_ZERO, PH_DIGITS})) begin
                n_out_hash = r_hash_tab;
            end else begin
                n_out_hash   = r_hash_tab;
                n_out_stored = w_stored;
                n_verdict    = (w_stored == r_hash_tab) ? V_VALID : V_INVALID;
            end
        end else begin
            if (r_len == '0 && r_in_byte == CH_HASH) begin
                n_comment = 1'b1;
            end
            if (r_in_byte == CH_TAB) begin
                n_hash_tab = r_hash;
                n_tab_seen = 1'b1;
                n_phase    = PH_LEAD;
                n_neg      = 1'b0;
                n_parsed   = 64'd0;
                n_ovf      = 1'b0;
            end else begin
                n_phase  = w_phase_step;
                n_neg    = w_neg_step;
                n_parsed = w_parsed_step;
                n_ovf    = w_ovf_step;
            end
            n_hash = w_hash_step;
            n_len  = w_len_inc;
            // A full chunk without a newline closes as invalid.
            w_emit = (w_len_inc == LEN_LAST);
        end

        // A closed chunk (or a bare end of stream) restarts the chunk state.
        if (w_emit || r_in_eos) begin
            n_hash     = FNV_OFFSET;
            n_hash_tab = 32'd0;
            n_tab_seen = 1'b0;
            n_phase    = PH_LEAD;
            n_neg      = 1'b0;
            n_parsed   = 64'd0;
            n_ovf      = 1'b0;
            n_len      = '0;
            n_comment  = 1'b0;
        end
        if (w_emit && n_verdict == V_VALID && r_good != '1) begin
            n_good = r_good + 32'd1;
        end
        if (w_emit && n_verdict == V_INVALID && r_bad != '1) begin
            n_bad = r_bad + 32'd1;
        end
    end

    // Chunk state registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hash     <= FNV_OFFSET;
            r_hash_tab <= 32'd0;
            r_tab_seen <= 1'b0;
            r_phase    <= PH_LEAD;
            r_neg      <= 1'b0;
            r_parsed   <= 64'd0;
            r_ovf      <= 1'b0;
            r_len      <= '0;
            r_comment  <= 1'b0;
            r_good     <= 32'd0;
            r_bad      <= 32'd0;
        end else if (w_advance) begin
            r_hash     <= n_hash;
            r_hash_tab <= n_hash_tab;
            r_tab_seen <= n_tab_seen;
            r_phase    <= n_phase;
            r_neg      <= n_neg;
            r_parsed   <= n_parsed;
            r_ovf      <= n_ovf;
            r_len      <= n_len;
            r_comment  <= n_comment;
            r_good     <= n_good;
            r_bad      <= n_bad;
        end
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_advance && w_emit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance && w_emit) begin
            r_verdict    <= n_verdict;
            r_out_hash   <= n_out_hash;
            r_out_stored <= n_out_stored;
        end
    end

    // Counters on the result beat are the totals including that chunk, which
    // the state registers hold until the next result is loaded.
    assign o_out_valid     = r_out_valid;
    assign o_verdict       = r_verdict;
    assign o_valid_count   = r_good;
    assign o_invalid_count = r_bad;
    assign o_computed_hash = r_out_hash;
    assign o_stored_value  = r_out_stored;

endmodule
